// ===== sv/classic_source_rewriter_top_assert.svh =====
// assertion macros for the classic source rewriter
`ifndef CLASSIC_SOURCE_REWRITER_TOP_ASSERT_SVH
`define CLASSIC_SOURCE_REWRITER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CSRW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/csrw_pkg.sv =====
// shared types, constants and character helpers for the source rewriter
`default_nettype none

package csrw_pkg;

   // most results one request can produce
   localparam int MAX_RESULTS = 6;
   localparam int COUNT_W     = 3;
   // entries in the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   // characters of interest
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // one queue entry: the results of one request
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [COUNT_W-1:0]          count;
      logic                        is_end;
   } csrw_entry_type;

   // letters of the opening keyword
   function automatic logic [7:0] open_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h62;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h67;
         3'd3:    c = 8'h69;
         3'd4:    c = 8'h6E;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // letters of the closing keyword
   function automatic logic [7:0] close_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h65;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h64;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // digits, letters and underscore
   function automatic logic is_ident(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
   endfunction

endpackage

`default_nettype wire

// ===== sv/csrw_ifs.sv =====
// request, response and register-write channel interfaces
`default_nettype none

interface csrw_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;
   modport source (output valid, output kind, output in_byte, input ready);
   modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface csrw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       text_done;
   modport source (output valid, output out_byte, output byte_valid,
                   output run_last, output text_done, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input run_last, input text_done, output ready);
endinterface

interface csrw_csr_if;
   logic valid;
   logic ready;
   logic classic_mode;
   modport source (output valid, output classic_mode, input ready);
   modport sink   (input valid, input classic_mode, output ready);
endinterface

`default_nettype wire

// ===== sv/csrw_front.sv =====
// front end: accepts requests, tracks scan state and builds result groups
`default_nettype none

module csrw_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   csrw_req_if.sink                  req_chan,
   csrw_csr_if.sink                  csr_chan,
   input  wire logic                 queue_full,
   output logic                      push,
   output csrw_pkg::csrw_entry_type  push_entry
);
   import csrw_pkg::*;

   typedef enum logic [1:0] {
      MODE_CODE,
      MODE_STRING,
      MODE_LINE,
      MODE_BLOCK
   } scan_mode_type;

   scan_mode_type mode_ff, mode_in;
   logic          classic_ff, classic_in;
   logic          squote_ff, squote_in;
   logic [7:0]    prev_ff, prev_in;
   logic          cand_ff, cand_in;
   logic [2:0]    wlen_ff, wlen_in;
   logic          slash_ff, slash_in;
   logic          star_ff, star_in;

   logic                        accept;
   logic                        csr_accept;
   logic [7:0]                  ch;
   logic                        held_open;
   logic [2:0]                  raw_len;
   logic [2:0]                  brace_len;
   logic [2:0]                  word_len;
   logic [7:0]                  want;
   logic [7:0]                  quote;
   logic [MAX_RESULTS-1:0][7:0] raw_chars;
   logic [MAX_RESULTS-1:0][7:0] brace_chars;
   logic [MAX_RESULTS-1:0][7:0] pre_chars;
   logic [2:0]                  pre_len;
   logic [7:0]                  tail0;
   logic [7:0]                  tail1;
   logic [1:0]                  tail_len;
   logic                        run_code;
   logic                        end_mark;
   logic [3:0]                  total;

   assign ch             = req_chan.in_byte;
   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;

   // held word: which keyword it is and its raw and brace forms
   always_comb begin
      held_open = (wlen_ff != 3'd0) && (wlen_ff <= 3'd5) &&
                  (prev_ff == open_char(3'(wlen_ff - 3'd1)));
      raw_len   = held_open ? wlen_ff : ((wlen_ff > 3'd3) ? 3'd3 : wlen_ff);
      brace_len = (wlen_ff == 3'd5) ? 3'd5 : 3'd3;
      word_len  = held_open ? 3'd5 : 3'd3;
      want      = held_open ? open_char(wlen_ff) : close_char(wlen_ff);
      quote     = squote_ff ? CH_SQUOTE : CH_DQUOTE;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         raw_chars[i]   = held_open ? open_char(3'(i)) : close_char(3'(i));
         brace_chars[i] = CH_SPACE;
      end
      brace_chars[0] = (wlen_ff == 3'd5) ? CH_LBRACE : CH_RBRACE;
   end

   // next scan state and the results of this request
   always_comb begin
      mode_in    = mode_ff;
      classic_in = classic_ff;
      squote_in  = squote_ff;
      prev_in    = prev_ff;
      cand_in    = cand_ff;
      wlen_in    = wlen_ff;
      slash_in   = slash_ff;
      star_in    = star_ff;
      pre_chars  = '0;
      pre_len    = 3'd0;
      tail0      = CH_NUL;
      tail1      = CH_NUL;
      tail_len   = 2'd0;
      run_code   = 1'b0;
      end_mark   = 1'b0;

      if (req_chan.kind) begin
         // end of text: flush what is held, then the done marker
         if (cand_ff) begin
            pre_chars = brace_chars;
            pre_len   = brace_len;
         end else if (wlen_ff != 3'd0) begin
            pre_chars = raw_chars;
            pre_len   = raw_len;
         end else if (slash_ff) begin
            pre_chars[0] = CH_SLASH;
            pre_len      = 3'd1;
         end
         tail_len  = 2'd1;
         end_mark  = 1'b1;
         mode_in   = MODE_CODE;
         squote_in = 1'b0;
         prev_in   = CH_NUL;
         cand_in   = 1'b0;
         wlen_in   = 3'd0;
         slash_in  = 1'b0;
         star_in   = 1'b0;
      end else if (!classic_ff) begin
         tail0    = ch;
         tail_len = 2'd1;
      end else begin
         prev_in = ch;
         unique case (mode_ff)
            MODE_STRING: begin
               if (ch == CH_BSLASH) begin
                  tail0    = CH_BSLASH;
                  tail1    = ch;
                  tail_len = 2'd2;
               end else begin
                  tail0    = ch;
                  tail_len = 2'd1;
               end
               if (ch == quote) begin
                  mode_in = MODE_CODE;
               end
            end
            MODE_LINE: begin
               tail0    = ch;
               tail_len = 2'd1;
               if (ch == CH_LF || ch == CH_CR) begin
                  mode_in = MODE_CODE;
               end
            end
            MODE_BLOCK: begin
               tail0    = ch;
               tail_len = 2'd1;
               if (star_ff && ch == CH_SLASH) begin
                  star_in = 1'b0;
                  mode_in = MODE_CODE;
               end else begin
                  star_in = (ch == CH_STAR);
               end
            end
            MODE_CODE: begin
               if (slash_ff) begin
                  slash_in     = 1'b0;
                  pre_chars[0] = CH_SLASH;
                  pre_len      = 3'd1;
                  if (ch == CH_SLASH) begin
                     tail0    = ch;
                     tail_len = 2'd1;
                     mode_in  = MODE_LINE;
                  end else if (ch == CH_STAR) begin
                     tail0    = ch;
                     tail_len = 2'd1;
                     mode_in  = MODE_BLOCK;
                     star_in  = 1'b0;
                  end else begin
                     run_code = 1'b1;
                  end
               end else if (cand_ff) begin
                  // a full word decides on the byte after it
                  if (is_ident(ch)) begin
                     pre_chars = raw_chars;
                     pre_len   = raw_len;
                  end else begin
                     pre_chars = brace_chars;
                     pre_len   = brace_len;
                  end
                  cand_in  = 1'b0;
                  wlen_in  = 3'd0;
                  run_code = 1'b1;
               end else if (wlen_ff != 3'd0) begin
                  if (wlen_ff < word_len && ch == want) begin
                     wlen_in = 3'(wlen_ff + 3'd1);
                     if (3'(wlen_ff + 3'd1) == word_len) begin
                        cand_in = 1'b1;
                     end
                  end else begin
                     pre_chars = raw_chars;
                     pre_len   = raw_len;
                     wlen_in   = 3'd0;
                     run_code  = 1'b1;
                  end
               end else begin
                  run_code = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_CODE;
            end
         endcase

         // code byte with nothing held
         if (run_code) begin
            if ((ch == CH_LOW_B || ch == CH_LOW_E) && !is_ident(prev_ff)) begin
               wlen_in = 3'd1;
            end else if (ch == CH_SLASH) begin
               slash_in = 1'b1;
            end else begin
               tail0    = ch;
               tail_len = 2'd1;
               if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                  mode_in   = MODE_STRING;
                  squote_in = (ch == CH_SQUOTE);
               end
            end
         end
      end

      // register write returns the scan state to its start
      if (csr_accept) begin
         classic_in = csr_chan.classic_mode;
         mode_in    = MODE_CODE;
         squote_in  = 1'b0;
         prev_in    = CH_NUL;
         cand_in    = 1'b0;
         wlen_in    = 3'd0;
         slash_in   = 1'b0;
         star_in    = 1'b0;
      end
   end

   // pack flushed bytes followed by the tail into one entry
   always_comb begin
      total = {1'b0, pre_len} + 4'(tail_len);
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (COUNT_W'(i) < pre_len) begin
            push_entry.chars[i] = pre_chars[i];
         end else if (COUNT_W'(i) == pre_len) begin
            push_entry.chars[i] = tail0;
         end else begin
            push_entry.chars[i] = tail1;
         end
      end
      push_entry.count  = total[COUNT_W-1:0];
      push_entry.is_end = end_mark;
   end

   assign push = accept && (total != 4'd0);

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CODE;
         classic_ff <= 1'b0;
         squote_ff  <= 1'b0;
         prev_ff    <= CH_NUL;
         cand_ff    <= 1'b0;
         wlen_ff    <= 3'd0;
         slash_ff   <= 1'b0;
         star_ff    <= 1'b0;
      end else if (accept || csr_accept) begin
         mode_ff    <= mode_in;
         classic_ff <= classic_in;
         squote_ff  <= squote_in;
         prev_ff    <= prev_in;
         cand_ff    <= cand_in;
         wlen_ff    <= wlen_in;
         slash_ff   <= slash_in;
         star_ff    <= star_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/csrw_queue.sv =====
// short queue of result groups between front and back
`default_nettype none

module csrw_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire csrw_pkg::csrw_entry_type push_entry,
   input  wire logic                     pop,
   output logic                          full,
   output logic                          empty,
   output csrw_pkg::csrw_entry_type      head
);
   import csrw_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   csrw_entry_type   entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/csrw_back.sv =====
// back end: plays each result group out one result per cycle while the receiver is ready
`default_nettype none

module csrw_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     queue_empty,
   input  wire csrw_pkg::csrw_entry_type head,
   output logic                          pop,
   csrw_rsp_if.source                    rsp_chan
);
   import csrw_pkg::*;

   csrw_entry_type     cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               last;
   logic               take;
   logic               load;

   assign last = (COUNT_W'(idx_ff + 1'b1) == cur_ff.count);
   assign take = rsp_chan.valid && rsp_chan.ready;
   assign load = !cur_valid_ff || (take && last);
   assign pop  = load && !queue_empty;

   // response fields come straight from the held group
   assign rsp_chan.valid      = cur_valid_ff;
   assign rsp_chan.out_byte   = cur_ff.chars[idx_ff];
   assign rsp_chan.byte_valid = !(cur_ff.is_end && last);
   assign rsp_chan.run_last   = last;
   assign rsp_chan.text_done  = cur_ff.is_end && last;

   // next group or next slot
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = head;
         cur_valid_in = !queue_empty;
         idx_in       = '0;
      end else if (take) begin
         idx_in = COUNT_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

// ===== sv/classic_source_rewriter_top.sv =====
// Classic source rewriter, top level.
// req_chan takes one request per handshake: a source byte (kind 0) or the
// end-of-text marker (kind 1). rsp_chan gives zero to six results per
// request, in order; run_last marks the last result of a request and
// text_done the final result after the end marker (byte_valid is 0 there).
// csr_chan writes classic_mode; ready is always high, and a write also
// restarts the scan state. Write it only while no results are outstanding.
// Requests are taken one per cycle while the four-entry group queue has
// room; a byte held for a word or comment decision takes no queue entry.
// A request's results pass through the group queue and then the output
// register, and results leave one per cycle while the receiver is ready.
// A stalled receiver holds the current result steady; the queue fills and
// then req_chan ready drops until space frees up.
// Reset (synchronous) clears the queue, the output stage and the scan
// state, and sets classic_mode to 0 (pass-through).
`default_nettype none

module classic_source_rewriter_top (
   input  wire logic  clock,
   input  wire logic  reset,
   csrw_req_if.sink   req_chan,
   csrw_rsp_if.source rsp_chan,
   csrw_csr_if.sink   csr_chan
);
   import csrw_pkg::*;

   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;
   csrw_entry_type push_entry;
   csrw_entry_type head;

   // classification and scan state
   csrw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   csrw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // result serialiser
   csrw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // checks
`include "classic_source_rewriter_top_assert.svh"

   `CSRW_ASSERT_NOW(a_no_push_full, clock, reset, push, !queue_full, "push into full queue")
   `CSRW_ASSERT_NOW(a_group_size, clock, reset, push, push_entry.count != '0 && push_entry.count <= COUNT_W'(MAX_RESULTS), "bad group size")
   `CSRW_ASSERT_NOW(a_done_form, clock, reset, rsp_chan.valid && rsp_chan.text_done, rsp_chan.run_last && !rsp_chan.byte_valid, "done result malformed")
   `CSRW_ASSERT_NEXT(a_group_runs_on, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last, rsp_chan.valid, "group cut short")

endmodule

`default_nettype wire

// ===== tb/sv/csrw_rewrite_checker.sv =====
// rewrite checker: predicts each request's results and compares them with the response channel
module csrw_rewrite_checker
   import csrw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   csrw_req_if       req_mon,
   csrw_rsp_if       rsp_mon,
   csrw_csr_if       csr_mon,
   output int        mismatches,
   output int        results_pending
);

   // what the scanner is inside of
   typedef enum logic [1:0] {
      SCAN_CODE,
      SCAN_STRING,
      SCAN_LINE_NOTE,
      SCAN_BLOCK_NOTE
   } scan_state_e;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_done;
   } rewrite_result_t;

   localparam logic [39:0] OPEN_WORD   = "begin";
   localparam logic [23:0] CLOSE_WORD  = "end";
   localparam int          PRINT_LIMIT = 20;

   // predictor state
   logic            classic_on;
   scan_state_e     scan;
   logic            quote_single;
   logic [7:0]      last_char;
   logic            word_complete;
   logic [2:0]      held_len;
   logic            slash_pending;
   logic            star_pending;
   int              produced;
   rewrite_result_t expected_output[$];

   function automatic logic [7:0] open_at(input int pos);
      return OPEN_WORD[8*(4-pos) +: 8];
   endfunction

   function automatic logic [7:0] close_at(input int pos);
      return CLOSE_WORD[8*(2-pos) +: 8];
   endfunction

   // digits, letters of either case, underscore
   function automatic logic word_byte(input logic [7:0] c);
      logic [7:0] folded;
      folded = c & 8'hDF;
      return (folded >= "A" && folded <= "Z") || (c >= "0" && c <= "9") || c == "_";
   endfunction

   function automatic void restart_scan();
      scan          = SCAN_CODE;
      quote_single  = 1'b0;
      last_char     = CH_NUL;
      word_complete = 1'b0;
      held_len      = 3'd0;
      slash_pending = 1'b0;
      star_pending  = 1'b0;
   endfunction

   function automatic void queue_result(input logic [7:0] ch, input logic carries,
                                        input logic done);
      rewrite_result_t r;
      if (produced >= MAX_RESULTS) return;
      r.out_byte   = ch;
      r.byte_valid = carries;
      r.run_last   = 1'b0;
      r.text_done  = done;
      expected_output.push_back(r);
      produced++;
   endfunction

   // the held letters belong to "begin" when the last one sits at its place there
   function automatic logic held_is_begin();
      return held_len != 3'd0 && held_len <= 3'd5 &&
             last_char == open_at(int'(held_len) - 1);
   endfunction

   function automatic void release_held_letters();
      logic as_begin;
      as_begin = held_is_begin();
      for (int i = 0; i < int'(held_len) && i < 5; i++) begin
         if (as_begin)
            queue_result(open_at(i), 1'b1, 1'b0);
         else if (i < 3)
            queue_result(close_at(i), 1'b1, 1'b0);
      end
   endfunction

   // brace padded with spaces to the keyword's length
   function automatic void queue_brace();
      int word_len;
      word_len = (held_len == 3'd5) ? 5 : 3;
      queue_result(word_len == 5 ? CH_LBRACE : CH_RBRACE, 1'b1, 1'b0);
      for (int i = 1; i < word_len; i++)
         queue_result(CH_SPACE, 1'b1, 1'b0);
   endfunction

   // code byte with nothing held
   function automatic void take_code_char(input logic [7:0] ch);
      if ((ch == CH_LOW_B || ch == CH_LOW_E) && !word_byte(last_char)) begin
         held_len = 3'd1;
         return;
      end
      if (ch == CH_SLASH) begin
         slash_pending = 1'b1;
         return;
      end
      if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
         scan         = SCAN_STRING;
         quote_single = (ch == CH_SQUOTE);
      end
      queue_result(ch, 1'b1, 1'b0);
   endfunction

   function automatic void scan_code_char(input logic [7:0] ch);
      logic       as_begin;
      logic [7:0] next_letter;
      int         word_len;
      if (slash_pending) begin
         // a held slash decides between comment starts and plain code
         slash_pending = 1'b0;
         queue_result(CH_SLASH, 1'b1, 1'b0);
         if (ch == CH_SLASH) begin
            queue_result(ch, 1'b1, 1'b0);
            scan = SCAN_LINE_NOTE;
         end else if (ch == CH_STAR) begin
            queue_result(ch, 1'b1, 1'b0);
            scan         = SCAN_BLOCK_NOTE;
            star_pending = 1'b0;
         end else begin
            take_code_char(ch);
         end
      end else if (word_complete) begin
         // full keyword held, the following byte says whether it is whole
         if (word_byte(ch))
            release_held_letters();
         else
            queue_brace();
         word_complete = 1'b0;
         held_len      = 3'd0;
         take_code_char(ch);
      end else if (held_len != 3'd0) begin
         // part of a keyword held
         as_begin    = held_is_begin();
         word_len    = as_begin ? 5 : 3;
         next_letter = CH_NUL;
         if (held_len < word_len)
            next_letter = as_begin ? open_at(held_len) : close_at(held_len);
         if (held_len < word_len && ch == next_letter) begin
            held_len = held_len + 3'd1;
            if (held_len == word_len)
               word_complete = 1'b1;
         end else begin
            release_held_letters();
            held_len = 3'd0;
            take_code_char(ch);
         end
      end else begin
         take_code_char(ch);
      end
   endfunction

   function automatic void scan_char(input logic [7:0] ch);
      case (scan)
         SCAN_STRING: begin
            if (ch == CH_BSLASH)
               queue_result(CH_BSLASH, 1'b1, 1'b0);
            queue_result(ch, 1'b1, 1'b0);
            if (ch == (quote_single ? CH_SQUOTE : CH_DQUOTE))
               scan = SCAN_CODE;
         end
         SCAN_LINE_NOTE: begin
            queue_result(ch, 1'b1, 1'b0);
            if (ch == CH_LF || ch == CH_CR)
               scan = SCAN_CODE;
         end
         SCAN_BLOCK_NOTE: begin
            queue_result(ch, 1'b1, 1'b0);
            if (star_pending && ch == CH_SLASH) begin
               star_pending = 1'b0;
               scan         = SCAN_CODE;
            end else begin
               star_pending = (ch == CH_STAR);
            end
         end
         default: scan_code_char(ch);
      endcase
      last_char = ch;
   endfunction

   // expected results of one request, appended in order
   function automatic void rewrite_request(input logic end_marker, input logic [7:0] ch);
      rewrite_result_t r;
      produced = 0;
      if (end_marker) begin
         if (word_complete)
            queue_brace();
         else if (held_len != 3'd0)
            release_held_letters();
         else if (slash_pending)
            queue_result(CH_SLASH, 1'b1, 1'b0);
         queue_result(CH_NUL, 1'b0, 1'b1);
         restart_scan();
      end else if (!classic_on) begin
         queue_result(ch, 1'b1, 1'b0);
      end else begin
         scan_char(ch);
      end
      if (produced > 0) begin
         r = expected_output.pop_back();
         r.run_last = 1'b1;
         expected_output.push_back(r);
      end
   endfunction

   // track register writes and requests, then compare results
   always @(posedge clock) begin : check_flow
      rewrite_result_t seen;
      rewrite_result_t want;
      if (reset) begin
         classic_on = 1'b0;
         restart_scan();
         expected_output.delete();
         mismatches      <= 0;
         results_pending <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            classic_on = csr_mon.classic_mode;
            restart_scan();
         end
         if (req_mon.valid && req_mon.ready)
            rewrite_request(req_mon.kind, req_mon.in_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.out_byte   = rsp_mon.out_byte;
            seen.byte_valid = rsp_mon.byte_valid;
            seen.run_last   = rsp_mon.run_last;
            seen.text_done  = rsp_mon.text_done;
            if (expected_output.size() == 0) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t: unexpected result: expected none, got byte %h valid %b last %b done %b",
                           $time, seen.out_byte, seen.byte_valid, seen.run_last,
                           seen.text_done);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_output.pop_front();
               if (seen !== want) begin
                  if (mismatches < PRINT_LIMIT)
                     $display("%0t: result mismatch: expected byte %h valid %b last %b done %b, got byte %h valid %b last %b done %b",
                              $time, want.out_byte, want.byte_valid, want.run_last,
                              want.text_done, seen.out_byte, seen.byte_valid,
                              seen.run_last, seen.text_done);
                  mismatches <= mismatches + 1;
               end
            end
         end
         results_pending <= expected_output.size();
      end
   end

endmodule

// ===== tb/sv/tb_classic_source_rewriter_top.sv =====
// testbench top for the classic source rewriter: stimulus, idling and verdict
module tb_classic_source_rewriter_top;
   import csrw_pkg::*;

   localparam int HOLD_OFF_CYCLES = 120;
   localparam int SETTLE_CYCLES   = 8;
   localparam int QUIET_LIMIT     = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int sent_items    = 0;
   int squeeze_count = 0;
   bit steady_flow   = 1'b0;
   int quiet_cycles  = 0;
   int mismatch_count;
   int results_pending;

   csrw_req_if req_chan ();
   csrw_rsp_if rsp_chan ();
   csrw_csr_if csr_chan ();

   classic_source_rewriter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   csrw_rewrite_checker rewrite_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_mon         (csr_chan),
      .mismatches      (mismatch_count),
      .results_pending (results_pending)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gap lengths: mostly none or short, now and then long
   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic int receiver_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // character pickers
   function automatic logic [7:0] any_ident_char();
      case ($urandom_range(0, 3))
         0:       return "a" + 8'($urandom_range(0, 25));
         1:       return "A" + 8'($urandom_range(0, 25));
         2:       return "0" + 8'($urandom_range(0, 9));
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] any_separator();
      case ($urandom_range(0, 6))
         0:       return " ";
         1:       return "\n";
         2:       return "(";
         3:       return ";";
         4:       return "\t";
         5:       return ".";
         default: return 8'h80 + 8'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [7:0] string_char();
      case ($urandom_range(0, 7))
         0, 1:    return CH_BSLASH;
         2:       return CH_DQUOTE;
         3:       return CH_SQUOTE;
         4:       return any_ident_char();
         5:       return CH_SPACE;
         6:       return CH_SLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] note_char();
      case ($urandom_range(0, 5))
         0, 1:    return CH_STAR;
         2:       return CH_SLASH;
         3:       return CH_SPACE;
         4:       return CH_LF;
         default: return any_ident_char();
      endcase
   endfunction

   // one request, after an optional gap, held until taken
   task automatic send_request(input logic end_marker, input logic [7:0] ch);
      int gap;
      gap = steady_flow ? 0 : sender_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= end_marker;
      req_chan.in_byte <= ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      send_request(1'b0, ch);
   endtask

   task automatic send_end();
      send_request(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // wait out every outstanding result, then the pipeline depth
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic on);
      csr_chan.valid        <= 1'b1;
      csr_chan.classic_mode <= on;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // one piece of source text, mostly well formed
   task automatic send_fragment();
      int         pick;
      int         n;
      logic [7:0] quote;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         // keyword with a separator or identifier byte either side
         send_byte($urandom_range(0, 3) == 0 ? any_ident_char() : any_separator());
         if ($urandom_range(0, 1))
            send_chars("begin");
         else
            send_chars("end");
         if ($urandom_range(0, 5) == 0)
            send_end();
         else
            send_byte($urandom_range(0, 3) == 0 ? any_ident_char() : any_separator());
      end else if (pick < 30) begin
         // keyword cut short or run together
         case ($urandom_range(0, 6))
            0:       send_chars("b");
            1:       send_chars("be");
            2:       send_chars("beg");
            3:       send_chars("begi");
            4:       send_chars("e");
            5:       send_chars("en");
            default: send_chars("bebeg");
         endcase
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 44) begin
         // quoted string, sometimes left open
         quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
         send_byte(quote);
         n = $urandom_range(0, 6);
         repeat (n) send_byte(string_char());
         if ($urandom_range(0, 4) != 0)
            send_byte(quote);
      end else if (pick < 54) begin
         // line comment
         send_chars("//");
         n = $urandom_range(0, 5);
         repeat (n) send_byte(note_char());
         if ($urandom_range(0, 9) != 0)
            send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end else if (pick < 66) begin
         // block comment
         send_chars("/*");
         n = $urandom_range(0, 6);
         repeat (n) send_byte(note_char());
         if ($urandom_range(0, 4) != 0)
            send_chars("*/");
      end else if (pick < 78) begin
         n = $urandom_range(1, 4);
         repeat (n) send_byte(any_ident_char());
      end else if (pick < 87) begin
         // lone slash decided by what follows
         send_byte(CH_SLASH);
         case ($urandom_range(0, 3))
            0:       send_byte(CH_LOW_B);
            1:       send_byte(CH_DQUOTE);
            2:       send_byte(CH_SLASH);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end else if (pick < 97) begin
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_end();
      end
   endtask

   task automatic send_fragments(input int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) send_fragment();
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin : response_drain
      int stall;
      int squeezes_served;
      squeezes_served = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (squeeze_count != squeezes_served) begin
            squeezes_served++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = steady_flow ? 0 : receiver_gap();
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("tb_classic_source_rewriter_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin : stimulus
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= 1'b0;
      req_chan.in_byte      <= 8'h00;
      csr_chan.valid        <= 1'b0;
      csr_chan.classic_mode <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through out of reset
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_LOW_B);
      send_byte(CH_BSLASH);
      send_end();
      drain_results();

      // rewriting: keywords, flush at end of text, comments, escaped string
      write_mode(1'b1);
      send_chars("begin");
      send_end();
      send_chars("end ");
      send_chars("/**/");
      send_chars("//\n");
      send_chars("\"\\\"");
      send_end();

      // random text with idling on both sides, partial keyword left held
      send_fragments(120);
      send_chars("be");
      drain_results();

      // pass-through
      write_mode(1'b0);
      send_fragments(50);
      drain_results();

      // back-to-back requests while the receiver holds off
      write_mode(1'b1);
      steady_flow   <= 1'b1;
      squeeze_count <= squeeze_count + 1;
      send_fragments(100);
      send_byte(CH_SLASH);
      drain_results();

      // same setting again, dropping the held slash
      steady_flow <= 1'b0;
      write_mode(1'b1);
      send_fragments(70);
      send_end();
      drain_results();

      if (mismatch_count == 0 && results_pending == 0)
         $display("tb_classic_source_rewriter_top: done, clean");
      else
         $display("tb_classic_source_rewriter_top: done, errors");
      $finish;
   end

endmodule

// ===== classic_source_rewriter_top.f =====
+incdir+sv
sv/csrw_pkg.sv
sv/csrw_ifs.sv
sv/csrw_front.sv
sv/csrw_queue.sv
sv/csrw_back.sv
sv/classic_source_rewriter_top.sv
tb/sv/csrw_rewrite_checker.sv
tb/sv/tb_classic_source_rewriter_top.sv
